### rtl/cbt_pkg.sv
package cbt_pkg;

  // Field widths
  localparam int CLOCK_W    = 30;
  localparam int BAUD_W     = 20;
  localparam int SP_W       = 10;
  localparam int PRESC_W    = 27;
  localparam int SEG1_W     = 4;
  localparam int SEG2_W     = 2;
  localparam int QUANTA_W   = 5;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Divider step counter covers one step per dividend bit
  localparam int DIV_CNT_W  = $clog2(CLOCK_W);

  // Timing constants
  localparam logic [CLOCK_W-1:0]  CLOCK_RESET     = CLOCK_W'(42000000);
  localparam logic [QUANTA_W-1:0] QUANTA_MAX      = QUANTA_W'(18);
  localparam logic [QUANTA_W-1:0] QUANTA_FALLBACK = QUANTA_W'(9);
  localparam int                  SEG2_DIVISOR    = 7;
  // Smallest quanta count where (q + 1) / 7 reaches 2
  localparam logic [QUANTA_W-1:0] SEG2_STEP_Q     = QUANTA_W'(2 * SEG2_DIVISOR - 1);

  // Register index of clock_hz
  localparam logic REG_CLOCK_HZ = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RATE = 2'd1,
    STATUS_SP_EARLY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLK_START,
    ST_CLK_WAIT,
    ST_Q_START,
    ST_Q_WAIT,
    ST_FINISH
  } state_t;

  // Phase segment 2 length: (q + 1) / 7 for q in 9..18
  function automatic logic [SEG2_W-1:0] seg2_of(input logic [QUANTA_W-1:0] q);
    seg2_of = (q >= SEG2_STEP_Q) ? SEG2_W'(2) : SEG2_W'(1);
  endfunction

  // Achieved sample point in permille: 1000 * (q - seg2) / q
  function automatic logic [SP_W-1:0] sample_point_of(input logic [QUANTA_W-1:0] q);
    unique case (q)
      5'd18:   sample_point_of = SP_W'(888);
      5'd17:   sample_point_of = SP_W'(882);
      5'd16:   sample_point_of = SP_W'(875);
      5'd15:   sample_point_of = SP_W'(866);
      5'd14:   sample_point_of = SP_W'(857);
      5'd13:   sample_point_of = SP_W'(846);
      5'd12:   sample_point_of = SP_W'(916);
      5'd11:   sample_point_of = SP_W'(909);
      5'd10:   sample_point_of = SP_W'(900);
      5'd9:    sample_point_of = SP_W'(888);
      default: sample_point_of = SP_W'(0);
    endcase
  endfunction

endpackage

### rtl/cbt_req_if.sv
interface cbt_req_if import cbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] baud_rate;
  logic [SP_W-1:0]   sample_point_permille;

  modport source (output valid, output baud_rate, output sample_point_permille, input ready);
  modport sink   (input valid, input baud_rate, input sample_point_permille, output ready);
endinterface

### rtl/cbt_res_if.sv
interface cbt_res_if import cbt_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [PRESC_W-1:0] prescaler;
  logic [SEG1_W-1:0]  segment_one;
  logic [SEG2_W-1:0]  segment_two;

  modport source (output valid, output status, output prescaler, output segment_one,
                  output segment_two, input ready);
  modport sink   (input valid, input status, input prescaler, input segment_one,
                  input segment_two, output ready);
endinterface

### rtl/can_bit_timing_calculator.sv
// CAN bit timing calculator.
// Configuration: APB-style port, one register clock_hz (byte address 0),
// written with a setup and an access cycle; pready is always high.
// Request channel (req): baud_rate and sample_point_permille, taken when
// valid and ready are high. One request is worked on at a time.
// Result channel (res): status, prescaler, segment_one, segment_two; one
// result for each request.
// Divisions: every division runs on one shared bit-serial divider
// (start, 30 steps, done). A request needs one division for clock/baud
// and, if that leaves no remainder, one per quanta count tried, 18 down
// to 9, until one divides the bit exactly or 9 is reached. A zero baud
// rate skips all divisions. The sequencer returns to idle as the result
// is registered and takes the next request from there.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the following result waits in
// the finish state and no new request is taken until the register frees.
// Reset: clock_hz returns to 42000000, the sequencer goes idle and any
// pending result is dropped.
module can_bit_timing_calculator import cbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  cbt_req_if.sink            req,
  cbt_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state, state_next;

  logic [CLOCK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0]   baud;
  logic [SP_W-1:0]     sp;
  logic [CLOCK_W-1:0]  ticks;
  logic [QUANTA_W-1:0] q;
  status_t             status_w;
  logic [PRESC_W-1:0]  presc_w;
  logic [SEG1_W-1:0]   seg1_w;
  logic [SEG2_W-1:0]   seg2_w;

  logic                div_start;
  logic [CLOCK_W-1:0]  div_dividend;
  logic [BAUD_W-1:0]   div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [CLOCK_W-1:0]  div_quo;
  logic [BAUD_W-1:0]   div_rem;

  logic                req_take;
  logic                res_free;
  logic                q_hit;
  logic [SEG2_W-1:0]   seg2_q;
  logic [QUANTA_W-1:0] seg1_q;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLOCK_HZ) ? PDATA_W'(clock_hz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CLOCK_HZ) begin
      clock_hz <= pwdata[CLOCK_W-1:0];
    end
  end

  // Shared divider
  assign div_dividend = (state == ST_CLK_START) ? clock_hz : ticks;
  assign div_divisor  = (state == ST_CLK_START) ? baud : BAUD_W'(q);

  cbt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Handshake terms
  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign res_free  = !res.valid || res.ready;
  assign q_hit     = (div_rem == '0) || (q == QUANTA_FALLBACK);
  assign seg2_q    = seg2_of(q);
  assign seg1_q    = q - QUANTA_W'(1) - QUANTA_W'(seg2_q);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider start
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = (req.baud_rate == '0) ? ST_FINISH : ST_CLK_START;
        end
      end
      ST_CLK_START: begin
        div_start  = 1'b1;
        state_next = ST_CLK_WAIT;
      end
      ST_CLK_WAIT: begin
        if (div_done) begin
          state_next = (div_rem == '0) ? ST_Q_START : ST_FINISH;
        end
      end
      ST_Q_START: begin
        div_start  = 1'b1;
        state_next = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (div_done) begin
          state_next = q_hit ? ST_FINISH : ST_Q_START;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          baud     <= req.baud_rate;
          sp       <= req.sample_point_permille;
          status_w <= STATUS_BAD_RATE;
          presc_w  <= '0;
          seg1_w   <= '0;
          seg2_w   <= '0;
        end
      end
      ST_CLK_WAIT: begin
        if (div_done) begin
          ticks <= div_quo;
          q     <= QUANTA_MAX;
        end
      end
      ST_Q_WAIT: begin
        if (div_done) begin
          if (q_hit) begin
            if (sample_point_of(q) < sp) begin
              status_w <= STATUS_SP_EARLY;
            end else begin
              status_w <= STATUS_OK;
              presc_w  <= div_quo[PRESC_W-1:0];
              seg1_w   <= seg1_q[SEG1_W-1:0];
              seg2_w   <= seg2_q;
            end
          end else begin
            q <= q - QUANTA_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_FINISH && res_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && res_free) begin
      res.status      <= status_w;
      res.prescaler   <= presc_w;
      res.segment_one <= seg1_w;
      res.segment_two <= seg2_w;
    end
  end

  // Checks
  a_div_idle_on_take: assert property (@(posedge clk) disable iff (rst)
    req_take |-> !div_busy)
    else $error("request taken while divider busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_CLK_WAIT || state == ST_Q_WAIT))
    else $error("divider finished outside a wait state");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != STATUS_OK) |->
      (res.prescaler == '0 && res.segment_one == '0 && res.segment_two == '0))
    else $error("failure result carries nonzero timing");

  a_ok_segments: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == STATUS_OK) |->
      ((res.segment_two == SEG2_W'(1) && res.segment_one >= SEG1_W'(7) &&
        res.segment_one <= SEG1_W'(10)) ||
       (res.segment_two == SEG2_W'(2) && res.segment_one >= SEG1_W'(10) &&
        res.segment_one <= SEG1_W'(15))))
    else $error("segment lengths out of range");

endmodule

### rtl/cbt_div.sv
// Restoring divider, one quotient bit per cycle
module cbt_div import cbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CLOCK_W-1:0] dividend,
  input  logic [BAUD_W-1:0]  divisor,
  output logic               busy,
  output logic               done,
  output logic [CLOCK_W-1:0] quotient,
  output logic [BAUD_W-1:0]  remainder
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [BAUD_W-1:0]    dsr;
  logic [BAUD_W:0]      shifted;
  logic                 fits;

  // Trial subtract of the next partial remainder
  assign shifted = {remainder, quotient[CLOCK_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(CLOCK_W - 1);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= fits ? BAUD_W'(shifted - {1'b0, dsr}) : shifted[BAUD_W-1:0];
      quotient  <= {quotient[CLOCK_W-2:0], fits};
    end
  end

endmodule

### tb/cbt_timing_monitor.sv
`timescale 1ns / 1ps

module cbt_timing_monitor import cbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  cbt_req_if                 req,
  cbt_res_if                 res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);

  typedef struct packed {
    status_t            status;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  segment_one;
    logic [SEG2_W-1:0]  segment_two;
  } bit_timing_t;

  localparam logic [PADDR_W-1:0] CLOCK_HZ_ADDR = PADDR_W'({REG_CLOCK_HZ, 2'b00});
  localparam int unsigned        PERMILLE_FULL = 1000;

  logic [CLOCK_W-1:0] clock_hz_q;
  bit_timing_t        timing_due[$];

  // Bit timing the block should report for one request at the given clock
  function automatic bit_timing_t calc_bit_timing(input logic [CLOCK_W-1:0] clk_hz,
                                                  input logic [BAUD_W-1:0]  baud,
                                                  input logic [SP_W-1:0]    sp_min);
    int unsigned ticks, quanta, seg1, seg2, sp_got;
    bit_timing_t t;
    t = '0;
    t.status = STATUS_OK;
    if (baud == '0 || (clk_hz % baud) != '0) begin
      t.status = STATUS_BAD_RATE;
      return t;
    end
    ticks = 32'(clk_hz) / 32'(baud);
    // first quanta count from the top that divides the bit exactly, else nine
    quanta = 32'(QUANTA_MAX);
    while (quanta > 32'(QUANTA_FALLBACK) && (ticks % quanta) != 0) quanta--;
    seg2 = (quanta + 1) / SEG2_DIVISOR;
    seg1 = quanta - (1 + seg2);
    sp_got = (PERMILLE_FULL * (1 + seg1)) / (1 + seg1 + seg2);
    if (sp_got < 32'(sp_min)) begin
      t.status = STATUS_SP_EARLY;
      return t;
    end
    t.prescaler   = PRESC_W'(ticks / quanta);
    t.segment_one = SEG1_W'(seg1);
    t.segment_two = SEG2_W'(seg2);
    return t;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checking, request capture and register tracking
  always @(posedge clk) begin
    bit_timing_t got, want;
    if (rst) begin
      clock_hz_q = CLOCK_RESET;
      timing_due.delete();
    end else begin
      if (res.valid && res.ready) begin
        got.status      = res.status;
        got.prescaler   = res.prescaler;
        got.segment_one = res.segment_one;
        got.segment_two = res.segment_two;
        if (timing_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0d prescaler %0d seg1 %0d seg2 %0d",
                   $time, got.status, got.prescaler, got.segment_one, got.segment_two);
          mismatches++;
        end else begin
          want = timing_due.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("prescaler", 64'(want.prescaler), 64'(got.prescaler));
          check_field("segment_one", 64'(want.segment_one), 64'(got.segment_one));
          check_field("segment_two", 64'(want.segment_two), 64'(got.segment_two));
        end
      end
      if (req.valid && req.ready)
        timing_due.push_back(calc_bit_timing(clock_hz_q, req.baud_rate,
                                             req.sample_point_permille));
      if (psel && penable && pwrite && pready && paddr == CLOCK_HZ_ADDR)
        clock_hz_q = pwdata[CLOCK_W-1:0];
    end
    outstanding = timing_due.size();
  end

endmodule

### tb/can_bit_timing_calculator_tb.sv
`timescale 1ns / 1ps

module can_bit_timing_calculator_tb;
  import cbt_pkg::*;

  localparam int unsigned        LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned        HOLD_CYCLES   = 3000;
  localparam int unsigned        DRAIN_CYCLES  = 400;
  localparam int unsigned        IDLE_PCT      = 38;
  localparam logic [PADDR_W-1:0] CLOCK_HZ_ADDR = PADDR_W'({REG_CLOCK_HZ, 2'b00});
  localparam logic [CLOCK_W-1:0] CLOCK_RICH    = CLOCK_W'(36756720);  // 2^4*3^3*5*7*11*13*17

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int unsigned        mismatches, outstanding;
  int unsigned        cycle_count;
  int unsigned        send_idle_pct = IDLE_PCT;
  int unsigned        take_idle_pct = IDLE_PCT;
  int unsigned        hold_seq;
  logic [CLOCK_W-1:0] clock_now;

  cbt_req_if req_ch();
  cbt_res_if res_ch();

  can_bit_timing_calculator dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cbt_timing_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("can_bit_timing_calculator verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for
  initial begin
    int unsigned hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Baud rate that divides the clock (a quanta count times a random factor), else random
  function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLOCK_W-1:0] clk_hz);
    int unsigned ticks;
    if (clk_hz == '0) return BAUD_W'($urandom());
    for (int i = 0; i < 512; i++) begin
      ticks = $urandom_range(18, 9) * $urandom_range(1, 1 << $urandom_range(16, 0));
      if ((32'(clk_hz) % ticks) == 0 && 32'(clk_hz) / ticks < (1 << BAUD_W))
        return BAUD_W'(32'(clk_hz) / ticks);
    end
    return BAUD_W'($urandom_range((1 << BAUD_W) - 1, 1));
  endfunction

  // mostly close to the achievable sample points
  function automatic logic [SP_W-1:0] pick_sample_point();
    if ($urandom_range(99) < 70) return SP_W'($urandom_range(920, 830));
    return SP_W'($urandom());
  endfunction

  task automatic send_request(input logic [BAUD_W-1:0] baud, input logic [SP_W-1:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid                 <= 1'b1;
    req_ch.baud_rate             <= baud;
    req_ch.sample_point_permille <= sp;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // APB write of clock_hz, only with the block idle
  task automatic write_clock(input logic [PDATA_W-1:0] value);
    wait_all_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CLOCK_HZ_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    clock_now = value[CLOCK_W-1:0];
  endtask

  task automatic run_phase(input logic [PDATA_W-1:0] clock_word, input int unsigned count);
    write_clock(clock_word);
    repeat (count) begin
      if ($urandom_range(99) < 80)
        send_request(pick_baud(clock_now), pick_sample_point());
      else if ($urandom_range(19) == 0)
        send_request('0, SP_W'($urandom()));
      else
        send_request(BAUD_W'($urandom()), SP_W'($urandom()));
    end
  endtask

  initial begin
    int unsigned b0, t0;
    req_ch.valid                 = 1'b0;
    req_ch.baud_rate             = '0;
    req_ch.sample_point_permille = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    clock_now = CLOCK_RESET;
    hold_seq  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset clock
    send_request(20'd0, 10'd0);          // zero baud rate
    send_request(20'hFFFFF, 10'd500);    // largest baud, not a divisor
    send_request(20'd41, 10'd0);
    send_request(20'd1, 10'd0);          // huge prescaler
    send_request(20'd1000000, 10'd857);  // sample point exactly met
    send_request(20'd1000000, 10'd858);
    send_request(20'd500000, 10'd0);
    send_request(20'd500000, 10'd1000);
    send_request(20'd500000, 10'h3FF);   // above 1000, never met
    send_request(20'd336000, 10'd888);   // no exact divisor, nine quanta
    send_request(20'd336000, 10'd889);
    send_request(20'd7, 10'd875);
    // zero clock
    write_clock(32'd0);
    send_request(20'd5, 10'd0);
    send_request(20'd1, 10'd889);
    send_request(20'd1, 10'd888);
    send_request(20'hFFFFF, 10'd0);
    // smallest clock
    write_clock(32'd1);
    send_request(20'd1, 10'd0);
    send_request(20'd2, 10'd0);
    // every clock bit set, upper data bits too
    write_clock(32'hFFFF_FFFF);
    send_request(20'd1, 10'd0);
    send_request(20'd1, 10'd917);
    send_request(20'd3, 10'd0);

    // random phases
    run_phase(32'(CLOCK_RICH), 100);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_phase(32'd80000000, 100);
    send_idle_pct = IDLE_PCT;
    take_idle_pct = IDLE_PCT;
    run_phase(32'd1000000000, 100);

    // long result stall while quick requests keep coming
    write_clock(32'd42000000);
    hold_seq++;
    repeat (16) begin
      if ($urandom_range(3) == 0) send_request(pick_baud(clock_now), pick_sample_point());
      else if ($urandom_range(1) == 0) send_request('0, pick_sample_point());
      else send_request(20'd41, pick_sample_point());
    end
    run_phase(32'd42000000, 56);

    repeat (9) begin
      if ($urandom_range(2) == 0) begin
        run_phase($urandom(), 80);
      end else begin
        b0 = $urandom_range(1000000, 1);
        t0 = $urandom_range(((1 << CLOCK_W) - 1) / b0, 1);
        if ($urandom_range(1) == 0 && 32'(CLOCK_RICH) <= ((1 << CLOCK_W) - 1) / b0)
          t0 = 32'(CLOCK_RICH) * $urandom_range(((1 << CLOCK_W) - 1) / b0 / 32'(CLOCK_RICH), 1);
        run_phase(b0 * t0, 80);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("can_bit_timing_calculator verification clean");
    end else begin
      $display("can_bit_timing_calculator verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cbt_pkg.sv
rtl/cbt_req_if.sv
rtl/cbt_res_if.sv
rtl/cbt_div.sv
rtl/can_bit_timing_calculator.sv
tb/cbt_timing_monitor.sv
tb/can_bit_timing_calculator_tb.sv
